### hw/rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI sequencer package
// Shared payload types and protocol constants for the SD SPI host sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam logic [1:0] REQ_CONT  = 2'd0;
    localparam logic [1:0] REQ_INIT  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_IDLE   = 3'd1;
    localparam logic [2:0] ST_INIT_TO   = 3'd2;
    localparam logic [2:0] ST_CMD_REJ   = 3'd3;
    localparam logic [2:0] ST_TOKEN_TO  = 3'd4;
    localparam logic [2:0] ST_DATA_REJ  = 3'd5;
    localparam logic [2:0] ST_BUSY_TO   = 3'd6;

    localparam logic [2:0] REG_RESP_POLL  = 3'd0;
    localparam logic [2:0] REG_TOKEN_POLL = 3'd1;
    localparam logic [2:0] REG_BUSY_POLL  = 3'd2;
    localparam logic [2:0] REG_ATTEMPTS   = 3'd3;
    localparam logic [2:0] REG_GAP        = 3'd4;

    // command selector
    typedef enum logic [2:0] {
        C_CMD0, C_CMD8, C_CMD55, C_ACMD41, C_CMD58, C_CMD17, C_CMD24
    } t_cmd;

    localparam logic [7:0] TOKEN_START = 8'hFE;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] lba;
        logic [7:0]  miso_byte;
        logic [7:0]  write_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       cs_active;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       write_taken;
        logic       done_res;
        logic [2:0] status;
        logic       block_mode;
        logic       fast_clock;
    } t_out;

    function automatic logic [7:0] cmd_code(t_cmd c);
        logic [7:0] v;
        unique case (c)
            C_CMD0:   v = 8'd0;
            C_CMD8:   v = 8'd8;
            C_CMD55:  v = 8'd55;
            C_ACMD41: v = 8'd41;
            C_CMD58:  v = 8'd58;
            C_CMD17:  v = 8'd17;
            C_CMD24:  v = 8'd24;
            default:  v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] cmd_crc(t_cmd c);
        logic [7:0] v;
        unique case (c)
            C_CMD0:  v = 8'h95;
            C_CMD8:  v = 8'h87;
            default: v = 8'h01;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/sdspi_frame.sv
// ----------------------------------------------------------------------------
// SD SPI command framer
// Picks one byte of a six-byte command frame: start+index, argument, CRC.
// ----------------------------------------------------------------------------
module sdspi_frame (
    input  sdspi_pkg::t_cmd i_cmd,
    input  logic [2:0]      i_idx,
    input  logic            i_card_v2,
    input  logic [31:0]     i_addr,
    output logic [7:0]      o_byte
);
    logic [31:0] arg;

    // argument per command
    always_comb begin
        unique case (i_cmd)
            sdspi_pkg::C_CMD8:   arg = 32'h0000_01AA;
            sdspi_pkg::C_ACMD41: arg = i_card_v2 ? 32'h4000_0000 : 32'h0;
            sdspi_pkg::C_CMD17,
            sdspi_pkg::C_CMD24:  arg = i_addr;
            default:             arg = 32'h0;
        endcase
    end

    // select frame byte
    always_comb begin
        unique case (i_idx)
            3'd0:    o_byte = 8'h40 | sdspi_pkg::cmd_code(i_cmd);
            3'd1:    o_byte = arg[31:24];
            3'd2:    o_byte = arg[23:16];
            3'd3:    o_byte = arg[15:8];
            3'd4:    o_byte = arg[7:0];
            default: o_byte = sdspi_pkg::cmd_crc(i_cmd);
        endcase
    end
endmodule

### hw/rtl/sd_spi_host_sequencer_unit.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer
// Byte-slot sequencer for SD card init, single block read and block write.
// ----------------------------------------------------------------------------
// One input beat is one SPI byte slot: it carries the card's byte from the
// previous slot and returns this slot's MOSI byte, chip select and status.
// Each beat is handled by the sequencer state register and a registered
// result stage, so a beat can be accepted every clock unless a held result
// is not taken. The output register holds a result until it is taken; a new
// beat is accepted in the same cycle that the held result is taken. The
// result is valid in the cycle after its beat is accepted.
module sd_spi_host_sequencer_unit #(
    parameter int WAKE_IDLE_BYTES = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sdspi_pkg::t_in     i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sdspi_pkg::t_out    o_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [19:0]        i_cfg_data
);
    localparam int BLOCK_BYTES = 512;
    localparam logic [9:0] BLK_LAST = 10'(BLOCK_BYTES - 1);
    localparam logic [9:0] WAKE_N = 10'(WAKE_IDLE_BYTES);

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE, PH_TAIL_R7, PH_TAIL_OCR, PH_GAP, PH_TOKEN, PH_RD_DATA,
        PH_RD_CRC2, PH_RD_END, PH_WR_DATA, PH_WR_CRC1, PH_WR_CRC2, PH_WR_RESP,
        PH_WR_CHECK, PH_BUSY, PH_FRAME, PH_POLL
    } t_phase;

    // configuration
    logic [7:0]  r_resp_lim;
    logic [15:0] r_tok_lim;
    logic [19:0] r_busy_lim;
    logic [11:0] r_att_lim;
    logic [15:0] r_gap_lim;

    // sequencer state
    t_phase          r_phase, n_phase;
    sdspi_pkg::t_cmd r_cmd, n_cmd;
    logic [9:0]      r_byte_cnt, n_byte_cnt;
    logic [19:0]     r_poll_cnt, n_poll_cnt;
    logic [11:0]     r_att_cnt, n_att_cnt;
    logic [15:0]     r_gap_cnt, n_gap_cnt;
    logic            r_card_v2, n_card_v2;
    logic            r_blk_addr, n_blk_addr;
    logic            r_fast, n_fast;
    logic [31:0]     r_addr, n_addr;

    logic            r_out_valid;
    sdspi_pkg::t_out r_out, n_out;

    logic            accept;
    logic [7:0]      miso;
    logic [7:0]      frame_byte;
    logic [2:0]      frame_idx;
    logic [19:0]     poll_inc;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign miso    = i_data.miso_byte;
    assign poll_inc = r_poll_cnt + 20'd1;

    // frame byte index: current slot in FRAME, else byte zero for a new frame
    assign frame_idx = (r_phase == PH_FRAME) ? r_byte_cnt[2:0] : 3'd0;

    sdspi_pkg::t_cmd frame_cmd;

    sdspi_frame u_frame (
        .i_cmd     (frame_cmd),
        .i_idx     (frame_idx),
        .i_card_v2 (n_card_v2),
        .i_addr    (n_addr),
        .o_byte    (frame_byte)
    );

    // next state and slot output
    always_comb begin
        logic start_frame;
        logic r1_hit;
        logic [7:0] resp_l;
        logic [15:0] tok_l;
        logic [19:0] busy_l;
        logic [11:0] att_l;
        logic [11:0] att_inc;
        resp_l = (r_resp_lim == 8'd0) ? 8'd1 : r_resp_lim;
        tok_l  = (r_tok_lim == 16'd0) ? 16'd1 : r_tok_lim;
        busy_l = (r_busy_lim == 20'd0) ? 20'd1 : r_busy_lim;
        att_l  = (r_att_lim == 12'd0) ? 12'd1 : r_att_lim;
        att_inc = r_att_cnt + 12'd1;
        start_frame = 1'b0;
        r1_hit = 1'b0;
        frame_cmd  = r_cmd;
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_byte_cnt = r_byte_cnt;
        n_poll_cnt = r_poll_cnt;
        n_att_cnt  = r_att_cnt;
        n_gap_cnt  = r_gap_cnt;
        n_card_v2  = r_card_v2;
        n_blk_addr = r_blk_addr;
        n_addr     = r_addr;
        n_fast     = r_fast;
        n_out = '0;
        n_out.mosi_byte = sdspi_pkg::IDLE_BYTE;

        if (r_phase == PH_IDLE && i_data.req_type == sdspi_pkg::REQ_INIT) begin
            n_fast = 1'b0;
        end
        n_out.fast_clock = (r_phase == PH_IDLE && i_data.req_type == sdspi_pkg::REQ_INIT)
                           ? 1'b0 : r_fast;

        unique case (r_phase)
            PH_FRAME: begin
                n_out.mosi_byte = frame_byte;
                n_out.cs_active = 1'b1;
                n_byte_cnt = r_byte_cnt + 10'd1;
                if (r_byte_cnt == 10'd5) begin
                    n_phase = PH_POLL;
                    n_poll_cnt = '0;
                end
            end
            PH_POLL: begin
                r1_hit = (r_poll_cnt != 20'd0) &&
                         (!miso[7] || r_poll_cnt >= {12'd0, resp_l});
                if (!r1_hit) begin
                    n_out.cs_active = 1'b1;
                    n_poll_cnt = poll_inc;
                end else begin
                    unique case (r_cmd)
                        sdspi_pkg::C_CMD0: begin
                            if (miso != 8'h01) begin
                                n_out.done_res = 1'b1;
                                n_out.status = sdspi_pkg::ST_NO_IDLE;
                                n_phase = PH_IDLE;
                            end else begin
                                start_frame = 1'b1; frame_cmd = sdspi_pkg::C_CMD8;
                            end
                        end
                        sdspi_pkg::C_CMD8: begin
                            n_card_v2 = (miso == 8'h01);
                            if (miso == 8'h01) begin
                                n_out.cs_active = 1'b1;
                                n_phase = PH_TAIL_R7;
                                n_byte_cnt = 10'd1;
                            end else begin
                                n_att_cnt = '0;
                                start_frame = 1'b1; frame_cmd = sdspi_pkg::C_CMD55;
                            end
                        end
                        sdspi_pkg::C_CMD55: begin
                            start_frame = 1'b1; frame_cmd = sdspi_pkg::C_ACMD41;
                        end
                        sdspi_pkg::C_ACMD41: begin
                            n_att_cnt = att_inc;
                            if (miso == 8'h00) begin
                                n_blk_addr = 1'b0;
                                if (r_card_v2) begin
                                    start_frame = 1'b1; frame_cmd = sdspi_pkg::C_CMD58;
                                end else begin
                                    n_out.done_res = 1'b1;
                                    n_phase = PH_IDLE;
                                    n_fast = 1'b1;
                                end
                            end else if (att_inc >= att_l) begin
                                n_out.done_res = 1'b1;
                                n_out.status = sdspi_pkg::ST_INIT_TO;
                                n_phase = PH_IDLE;
                            end else if (r_gap_lim == 16'd0) begin
                                start_frame = 1'b1; frame_cmd = sdspi_pkg::C_CMD55;
                            end else begin
                                n_out.cs_active = 1'b1;
                                n_phase = PH_GAP;
                                n_gap_cnt = 16'd1;
                            end
                        end
                        sdspi_pkg::C_CMD58: begin
                            if (miso == 8'h00) begin
                                n_out.cs_active = 1'b1;
                                n_phase = PH_TAIL_OCR;
                                n_byte_cnt = 10'd1;
                            end else begin
                                n_out.done_res = 1'b1;
                                n_phase = PH_IDLE;
                                n_fast = 1'b1;
                            end
                        end
                        sdspi_pkg::C_CMD17: begin
                            if (miso != 8'h00) begin
                                n_out.done_res = 1'b1;
                                n_out.status = sdspi_pkg::ST_CMD_REJ;
                                n_phase = PH_IDLE;
                            end else begin
                                n_out.cs_active = 1'b1;
                                n_phase = PH_TOKEN;
                                n_poll_cnt = 20'd1;
                            end
                        end
                        default: begin
                            if (miso != 8'h00) begin
                                n_out.done_res = 1'b1;
                                n_out.status = sdspi_pkg::ST_CMD_REJ;
                                n_phase = PH_IDLE;
                            end else begin
                                n_out.mosi_byte = sdspi_pkg::TOKEN_START;
                                n_out.cs_active = 1'b1;
                                n_phase = PH_WR_DATA;
                                n_byte_cnt = '0;
                            end
                        end
                    endcase
                end
            end
            PH_IDLE: begin
                if (i_data.req_type == sdspi_pkg::REQ_INIT) begin
                    n_byte_cnt = 10'd1;
                    n_phase = PH_WAKE;
                end else if (i_data.req_type == sdspi_pkg::REQ_READ ||
                             i_data.req_type == sdspi_pkg::REQ_WRITE) begin
                    n_addr = r_blk_addr ? i_data.lba : {i_data.lba[22:0], 9'd0};
                    start_frame = 1'b1;
                    frame_cmd = (i_data.req_type == sdspi_pkg::REQ_READ)
                                ? sdspi_pkg::C_CMD17 : sdspi_pkg::C_CMD24;
                end
            end
            PH_WAKE: begin
                if (r_byte_cnt >= WAKE_N) begin
                    start_frame = 1'b1; frame_cmd = sdspi_pkg::C_CMD0;
                end else begin
                    n_byte_cnt = r_byte_cnt + 10'd1;
                end
            end
            PH_TAIL_R7, PH_TAIL_OCR: begin
                if (r_phase == PH_TAIL_OCR && r_byte_cnt == 10'd1) begin
                    n_blk_addr = miso[6];
                end
                if (r_byte_cnt < 10'd4) begin
                    n_out.cs_active = 1'b1;
                    n_byte_cnt = r_byte_cnt + 10'd1;
                end else if (r_phase == PH_TAIL_R7) begin
                    n_att_cnt = '0;
                    start_frame = 1'b1; frame_cmd = sdspi_pkg::C_CMD55;
                end else begin
                    n_out.done_res = 1'b1;
                    n_phase = PH_IDLE;
                    n_fast = 1'b1;
                end
            end
            PH_GAP: begin
                if (r_gap_cnt >= r_gap_lim) begin
                    start_frame = 1'b1; frame_cmd = sdspi_pkg::C_CMD55;
                end else begin
                    n_out.cs_active = 1'b1;
                    n_gap_cnt = r_gap_cnt + 16'd1;
                end
            end
            PH_TOKEN: begin
                if (miso == sdspi_pkg::TOKEN_START) begin
                    n_out.cs_active = 1'b1;
                    n_phase = PH_RD_DATA;
                    n_byte_cnt = '0;
                end else if (r_poll_cnt >= {4'd0, tok_l}) begin
                    n_out.done_res = 1'b1;
                    n_out.status = sdspi_pkg::ST_TOKEN_TO;
                    n_phase = PH_IDLE;
                end else begin
                    n_out.cs_active = 1'b1;
                    n_poll_cnt = poll_inc;
                end
            end
            PH_RD_DATA: begin
                n_out.read_byte = miso;
                n_out.read_valid = 1'b1;
                n_out.cs_active = 1'b1;
                n_byte_cnt = r_byte_cnt + 10'd1;
                if (r_byte_cnt == BLK_LAST) n_phase = PH_RD_CRC2;
            end
            PH_RD_CRC2: begin
                n_out.cs_active = 1'b1;
                n_phase = PH_RD_END;
            end
            PH_RD_END: begin
                n_out.done_res = 1'b1;
                n_phase = PH_IDLE;
            end
            PH_WR_DATA: begin
                n_out.mosi_byte = i_data.write_byte;
                n_out.cs_active = 1'b1;
                n_out.write_taken = 1'b1;
                n_byte_cnt = r_byte_cnt + 10'd1;
                if (r_byte_cnt == BLK_LAST) n_phase = PH_WR_CRC1;
            end
            PH_WR_CRC1: begin
                n_out.cs_active = 1'b1; n_phase = PH_WR_CRC2;
            end
            PH_WR_CRC2: begin
                n_out.cs_active = 1'b1; n_phase = PH_WR_RESP;
            end
            PH_WR_RESP: begin
                n_out.cs_active = 1'b1; n_phase = PH_WR_CHECK;
            end
            PH_WR_CHECK: begin
                if (miso[4:0] != 5'h05) begin
                    n_out.done_res = 1'b1;
                    n_out.status = sdspi_pkg::ST_DATA_REJ;
                    n_phase = PH_IDLE;
                end else begin
                    n_out.cs_active = 1'b1;
                    n_phase = PH_BUSY;
                    n_poll_cnt = '0;
                end
            end
            PH_BUSY: begin
                if (miso != 8'h00) begin
                    n_out.done_res = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_poll_cnt = poll_inc;
                    if (poll_inc >= busy_l) begin
                        n_out.done_res = 1'b1;
                        n_out.status = sdspi_pkg::ST_BUSY_TO;
                        n_phase = PH_IDLE;
                    end else begin
                        n_out.cs_active = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // launch a command frame with its first byte
        if (start_frame) begin
            n_out.mosi_byte = frame_byte;
            n_out.cs_active = 1'b1;
            n_cmd = frame_cmd;
            n_phase = PH_FRAME;
            n_byte_cnt = 10'd1;
        end
        n_out.block_mode = n_blk_addr;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_lim <= 8'd10;
            r_tok_lim  <= 16'd8000;
            r_busy_lim <= 20'd100000;
            r_att_lim  <= 12'd1000;
            r_gap_lim  <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdspi_pkg::REG_RESP_POLL:  r_resp_lim <= i_cfg_data[7:0];
                sdspi_pkg::REG_TOKEN_POLL: r_tok_lim  <= i_cfg_data[15:0];
                sdspi_pkg::REG_BUSY_POLL:  r_busy_lim <= i_cfg_data;
                sdspi_pkg::REG_ATTEMPTS:   r_att_lim  <= i_cfg_data[11:0];
                sdspi_pkg::REG_GAP:        r_gap_lim  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // advance sequencer on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cmd       <= sdspi_pkg::C_CMD0;
            r_byte_cnt  <= '0;
            r_poll_cnt  <= '0;
            r_att_cnt   <= '0;
            r_gap_cnt   <= '0;
            r_card_v2   <= 1'b0;
            r_blk_addr  <= 1'b0;
            r_fast      <= 1'b0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_cmd      <= n_cmd;
                r_byte_cnt <= n_byte_cnt;
                r_poll_cnt <= n_poll_cnt;
                r_att_cnt  <= n_att_cnt;
                r_gap_cnt  <= n_gap_cnt;
                r_card_v2  <= n_card_v2;
                r_blk_addr <= n_blk_addr;
                r_fast     <= n_fast;
                r_addr     <= n_addr;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold result payload
    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // a finished job leaves chip select released
    a_done_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.done_res |-> !o_data.cs_active)
        else $error("done beat with chip select active");

    // status is only reported with done
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.done_res |-> o_data.status == sdspi_pkg::ST_OK)
        else $error("status without done");

    // a done beat returns the sequencer to idle
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_out.done_res |=> r_phase == PH_IDLE)
        else $error("sequencer not idle after done");

    // read and write data never share a beat
    a_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.read_valid && o_data.write_taken))
        else $error("read and write data in one beat");

endmodule

### tb/tb_sd_spi_host_sequencer_unit.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer testbench
// Drives byte slots with a card emulation and checks each slot against a
// behavioral predictor of the sequencer, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_sd_spi_host_sequencer_unit;

    localparam int BLOCK_BYTES = 512;
    localparam int WAKE_BYTES  = 10;

    typedef enum int {
        PH_IDLE, PH_WAKE, PH_TAIL_R7, PH_TAIL_OCR, PH_GAP, PH_TOKEN, PH_RD_DATA,
        PH_RD_CRC2, PH_RD_END, PH_WR_DATA, PH_WR_CRC1, PH_WR_CRC2, PH_WR_RESP,
        PH_WR_CHECK, PH_BUSY, PH_FRAME, PH_POLL
    } t_seq_phase;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    sdspi_pkg::t_in  i_data;
    logic            o_valid;
    logic            i_ready;
    sdspi_pkg::t_out o_data;
    logic            i_cfg_we;
    logic [2:0]      i_cfg_idx;
    logic [19:0]     i_cfg_data;

    sd_spi_host_sequencer_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state and registers
    logic [7:0]      lim_resp    = 8'd10;
    logic [15:0]     lim_token   = 16'd8000;
    logic [19:0]     lim_busy    = 20'd100000;
    logic [11:0]     lim_attempt = 12'd1000;
    logic [15:0]     gap_slots   = 16'd100;
    t_seq_phase      seq_ph      = PH_IDLE;
    sdspi_pkg::t_cmd seq_cmd     = sdspi_pkg::C_CMD0;
    int unsigned     byte_cnt    = 0;
    int unsigned     poll_cnt    = 0;
    int unsigned     gap_cnt     = 0;
    logic [11:0]     attempt_cnt = '0;
    logic [19:0]     busy_cnt    = '0;
    bit              card_v2     = 0;
    bit              blk_addr    = 0;
    bit              fast_ok     = 0;
    logic [31:0]     cmd_addr    = '0;

    sdspi_pkg::t_in  slot_queue[$];
    sdspi_pkg::t_out expected_slots[$];
    int              mismatch_count = 0;
    bit              cfg_busy       = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int unsigned at_least_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic logic [31:0] arg_of(sdspi_pkg::t_cmd c);
        case (c)
            sdspi_pkg::C_CMD8:   return 32'h0000_01AA;
            sdspi_pkg::C_ACMD41: return card_v2 ? 32'h4000_0000 : 32'h0;
            sdspi_pkg::C_CMD17,
            sdspi_pkg::C_CMD24:  return cmd_addr;
            default:             return 32'h0;
        endcase
    endfunction

    function automatic logic [7:0] frame_at(sdspi_pkg::t_cmd c, int unsigned k);
        logic [31:0] a;
        a = arg_of(c);
        if (k == 0) begin
            case (c)
                sdspi_pkg::C_CMD0:   return 8'h40;
                sdspi_pkg::C_CMD8:   return 8'h48;
                sdspi_pkg::C_CMD55:  return 8'h77;
                sdspi_pkg::C_ACMD41: return 8'h69;
                sdspi_pkg::C_CMD58:  return 8'h7A;
                sdspi_pkg::C_CMD17:  return 8'h51;
                default:             return 8'h58;
            endcase
        end
        if (k <= 4) return a[8*(4-k) +: 8];
        case (c)
            sdspi_pkg::C_CMD0: return 8'h95;
            sdspi_pkg::C_CMD8: return 8'h87;
            default:           return 8'h01;
        endcase
    endfunction

    task automatic set_reg(input logic [2:0] idx, input logic [19:0] val);
        case (idx)
            sdspi_pkg::REG_RESP_POLL:  lim_resp    = val[7:0];
            sdspi_pkg::REG_TOKEN_POLL: lim_token   = val[15:0];
            sdspi_pkg::REG_BUSY_POLL:  lim_busy    = val;
            sdspi_pkg::REG_ATTEMPTS:   lim_attempt = val[11:0];
            sdspi_pkg::REG_GAP:        gap_slots   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic start_frame(inout sdspi_pkg::t_out r, input sdspi_pkg::t_cmd c);
        r.mosi_byte = frame_at(c, 0);
        r.cs_active = 1'b1;
        seq_cmd  = c;
        seq_ph   = PH_FRAME;
        byte_cnt = 1;
    endtask

    task automatic end_job(inout sdspi_pkg::t_out r, input logic [2:0] st, input bit ok);
        r.mosi_byte = sdspi_pkg::IDLE_BYTE;
        r.cs_active = 1'b0;
        r.done_res  = 1'b1;
        r.status    = st;
        seq_ph      = PH_IDLE;
        if (ok) fast_ok = 1;
    endtask

    task automatic keep_idle(inout sdspi_pkg::t_out r);
        r.mosi_byte = sdspi_pkg::IDLE_BYTE;
        r.cs_active = 1'b1;
    endtask

    // act on a command's R1 response
    task automatic take_r1(inout sdspi_pkg::t_out r, input logic [7:0] r1);
        case (seq_cmd)
            sdspi_pkg::C_CMD0:
                if (r1 != 8'h01) end_job(r, sdspi_pkg::ST_NO_IDLE, 0);
                else start_frame(r, sdspi_pkg::C_CMD8);
            sdspi_pkg::C_CMD8: begin
                card_v2 = (r1 == 8'h01);
                if (card_v2) begin
                    keep_idle(r); seq_ph = PH_TAIL_R7; byte_cnt = 1;
                end else begin
                    attempt_cnt = 0; start_frame(r, sdspi_pkg::C_CMD55);
                end
            end
            sdspi_pkg::C_CMD55: start_frame(r, sdspi_pkg::C_ACMD41);
            sdspi_pkg::C_ACMD41: begin
                attempt_cnt = attempt_cnt + 1;
                if (r1 == 8'h00) begin
                    blk_addr = 0;
                    if (card_v2) start_frame(r, sdspi_pkg::C_CMD58);
                    else end_job(r, sdspi_pkg::ST_OK, 1);
                end else if (attempt_cnt >= at_least_one(lim_attempt)) begin
                    end_job(r, sdspi_pkg::ST_INIT_TO, 0);
                end else if (gap_slots == 0) begin
                    start_frame(r, sdspi_pkg::C_CMD55);
                end else begin
                    keep_idle(r); seq_ph = PH_GAP; gap_cnt = 1;
                end
            end
            sdspi_pkg::C_CMD58:
                if (r1 == 8'h00) begin
                    keep_idle(r); seq_ph = PH_TAIL_OCR; byte_cnt = 1;
                end else end_job(r, sdspi_pkg::ST_OK, 1);
            sdspi_pkg::C_CMD17:
                if (r1 != 8'h00) end_job(r, sdspi_pkg::ST_CMD_REJ, 0);
                else begin
                    keep_idle(r); seq_ph = PH_TOKEN; poll_cnt = 1;
                end
            default:
                if (r1 != 8'h00) end_job(r, sdspi_pkg::ST_CMD_REJ, 0);
                else begin
                    r.mosi_byte = sdspi_pkg::TOKEN_START; r.cs_active = 1'b1;
                    seq_ph = PH_WR_DATA; byte_cnt = 0;
                end
        endcase
    endtask

    // compute one slot's result and advance the predicted state
    task automatic predict_slot(input sdspi_pkg::t_in d, output sdspi_pkg::t_out r);
        logic [7:0] m;
        m = d.miso_byte;
        r = '0;
        r.mosi_byte = sdspi_pkg::IDLE_BYTE;
        if (seq_ph == PH_IDLE && d.req_type == sdspi_pkg::REQ_INIT) fast_ok = 0;
        r.fast_clock = fast_ok;
        case (seq_ph)
            PH_FRAME: begin
                r.mosi_byte = frame_at(seq_cmd, byte_cnt);
                r.cs_active = 1'b1;
                byte_cnt++;
                if (byte_cnt >= 6) begin
                    seq_ph = PH_POLL; poll_cnt = 0;
                end
            end
            PH_POLL:
                if (poll_cnt != 0 && (!m[7] || poll_cnt >= at_least_one(lim_resp)))
                    take_r1(r, m);
                else begin
                    keep_idle(r); poll_cnt++;
                end
            PH_IDLE:
                if (d.req_type == sdspi_pkg::REQ_INIT) begin
                    byte_cnt = 1; seq_ph = PH_WAKE;
                end else if (d.req_type == sdspi_pkg::REQ_READ ||
                             d.req_type == sdspi_pkg::REQ_WRITE) begin
                    cmd_addr = blk_addr ? d.lba : {d.lba[22:0], 9'd0};
                    if (d.req_type == sdspi_pkg::REQ_READ)
                        start_frame(r, sdspi_pkg::C_CMD17);
                    else
                        start_frame(r, sdspi_pkg::C_CMD24);
                end
            PH_WAKE:
                if (byte_cnt >= WAKE_BYTES) start_frame(r, sdspi_pkg::C_CMD0);
                else byte_cnt++;
            PH_TAIL_R7, PH_TAIL_OCR: begin
                if (seq_ph == PH_TAIL_OCR && byte_cnt == 1) blk_addr = m[6];
                if (byte_cnt < 4) begin
                    keep_idle(r); byte_cnt++;
                end else if (seq_ph == PH_TAIL_R7) begin
                    attempt_cnt = 0; start_frame(r, sdspi_pkg::C_CMD55);
                end else end_job(r, sdspi_pkg::ST_OK, 1);
            end
            PH_GAP:
                if (gap_cnt >= gap_slots) start_frame(r, sdspi_pkg::C_CMD55);
                else begin
                    keep_idle(r); gap_cnt++;
                end
            PH_TOKEN:
                if (m == sdspi_pkg::TOKEN_START) begin
                    keep_idle(r); seq_ph = PH_RD_DATA; byte_cnt = 0;
                end else if (poll_cnt >= at_least_one(lim_token))
                    end_job(r, sdspi_pkg::ST_TOKEN_TO, 0);
                else begin
                    keep_idle(r); poll_cnt++;
                end
            PH_RD_DATA: begin
                r.read_byte = m; r.read_valid = 1'b1;
                keep_idle(r);
                byte_cnt++;
                if (byte_cnt >= BLOCK_BYTES) seq_ph = PH_RD_CRC2;
            end
            PH_RD_CRC2: begin keep_idle(r); seq_ph = PH_RD_END; end
            PH_RD_END: end_job(r, sdspi_pkg::ST_OK, 0);
            PH_WR_DATA: begin
                r.mosi_byte = d.write_byte; r.cs_active = 1'b1; r.write_taken = 1'b1;
                byte_cnt++;
                if (byte_cnt >= BLOCK_BYTES) seq_ph = PH_WR_CRC1;
            end
            PH_WR_CRC1: begin keep_idle(r); seq_ph = PH_WR_CRC2; end
            PH_WR_CRC2: begin keep_idle(r); seq_ph = PH_WR_RESP; end
            PH_WR_RESP: begin keep_idle(r); seq_ph = PH_WR_CHECK; end
            PH_WR_CHECK:
                if (m[4:0] != 5'h05) end_job(r, sdspi_pkg::ST_DATA_REJ, 0);
                else begin
                    keep_idle(r); seq_ph = PH_BUSY; busy_cnt = 0;
                end
            PH_BUSY:
                if (m != 8'h00) end_job(r, sdspi_pkg::ST_OK, 0);
                else begin
                    busy_cnt = busy_cnt + 1;
                    if (busy_cnt >= at_least_one(lim_busy))
                        end_job(r, sdspi_pkg::ST_BUSY_TO, 0);
                    else keep_idle(r);
                end
            default: seq_ph = PH_IDLE;
        endcase
        r.block_mode = blk_addr;
    endtask

    // card emulation: build slots that answer the job in a plausible way
    function automatic sdspi_pkg::t_in mk_slot(logic [1:0] rq, logic [7:0] mi);
        sdspi_pkg::t_in s;
        s.req_type   = rq;
        s.lba        = $urandom;
        s.miso_byte  = mi;
        s.write_byte = 8'($urandom);
        return s;
    endfunction

    // queue n slots, each with miso drawn from a bias
    task automatic push_slots(input int n, input int mode);
        logic [7:0] mi;
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: mi = 8'($urandom);
                1: mi = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'h01;
                2: mi = ($urandom_range(0, 9) == 0) ? sdspi_pkg::TOKEN_START : 8'hFF;
                3: mi = ($urandom_range(0, 5) == 0) ? 8'hE5 : 8'h00;
                default: mi = sdspi_pkg::IDLE_BYTE;
            endcase
            slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, mi));
        end
    endtask

    // an init job answered by a v1 or v2 card after busy_tries busy ACMD41 replies
    task automatic push_init(input bit v2, input bit ccs, input int busy_tries);
        sdspi_pkg::t_in s;
        s = mk_slot(sdspi_pkg::REQ_INIT, sdspi_pkg::IDLE_BYTE);
        slot_queue.push_back(s);
        push_slots(WAKE_BYTES + 5, 4);
        slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, 8'h01));      // CMD0 R1
        push_slots(5, 4);
        slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, v2 ? 8'h01 : 8'h05)); // CMD8
        if (v2) push_slots(3, 0);
        for (int a = 0; a <= busy_tries; a++) begin
            push_slots(5, 4);
            slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, 8'h01));  // CMD55
            push_slots(5, 4);
            slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT,
                                         a == busy_tries ? 8'h00 : 8'h01));
            if (a != busy_tries) push_slots(gap_slots, 4);
        end
        if (v2) begin
            push_slots(5, 4);
            slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, 8'h00));
            slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, ccs ? 8'hC0 : 8'h80));
            push_slots(3, 0);
        end
        push_slots(2, 4);
    endtask

    task automatic push_xfer(input bit wr, input bit good);
        slot_queue.push_back(mk_slot(wr ? sdspi_pkg::REQ_WRITE : sdspi_pkg::REQ_READ,
                                     sdspi_pkg::IDLE_BYTE));
        push_slots(5, 4);
        push_slots($urandom_range(0, 2), 4);
        slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, good ? 8'h00 : 8'h04));
        if (!good) begin
            push_slots(2, 4);
            return;
        end
        if (!wr) begin
            push_slots($urandom_range(1, 6), 4);
            slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, sdspi_pkg::TOKEN_START));
            push_slots(BLOCK_BYTES + 2, 0);
        end else begin
            push_slots(BLOCK_BYTES + 3, 0);
            slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT,
                ($urandom_range(0, 4) == 0) ? 8'h0B : {3'($urandom), 5'h05}));
            push_slots($urandom_range(0, 5), 3);
            slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, 8'hFF));
        end
        push_slots(2, 4);
    endtask

    // wait for the block to drain, then write a register
    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        while (slot_queue.size() != 0 || i_valid || expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_busy   = 1;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        set_reg(idx, val);
        cfg_busy   = 0;
    endtask

    // driver: feed queued slots with random gaps
    int unsigned send_gap;
    always @(posedge i_clk) begin
        sdspi_pkg::t_out r;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_slot(i_data, r);
                expected_slots.push_back(r);
            end
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (slot_queue.size() != 0 && !cfg_busy) begin
                    i_data   <= slot_queue.pop_front();
                    i_valid  <= 1'b1;
                    send_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
                end else begin
                    i_valid  <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat and stall at random
    int unsigned stall_cnt;
    always @(posedge i_clk) begin
        sdspi_pkg::t_out e;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_slots.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat %h", o_data);
                end else begin
                    e = expected_slots.pop_front();
                    if (o_data !== e) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("beat differs: expected %p actual %p", e, o_data);
                    end
                end
            end
            if (stall_cnt != 0) begin
                stall_cnt <= stall_cnt - 1;
                i_ready   <= 1'b0;
            end else begin
                i_ready   <= 1'b1;
                if (o_valid && i_ready && $urandom_range(0, 3) == 0)
                    stall_cnt <= $urandom_range(0, 12);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = sdspi_pkg::REG_RESP_POLL; i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: transfers before init, extremes of lba and bytes
        slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, 8'h00));
        begin
            sdspi_pkg::t_in s;
            s = mk_slot(sdspi_pkg::REQ_READ, 8'hFF); s.lba = 32'hFFFF_FFFF;
            slot_queue.push_back(s);
        end
        push_slots(5, 4);
        slot_queue.push_back(mk_slot(sdspi_pkg::REQ_WRITE, 8'h00)); // start while busy
        push_slots(12, 4);                                  // R1 timeout, rejected
        slot_queue.push_back(mk_slot(sdspi_pkg::REQ_INIT, 8'hFF));
        push_slots(WAKE_BYTES + 6, 4);                      // CMD0 no idle
        push_slots(2, 4);

        write_reg(sdspi_pkg::REG_GAP, 20'd0);
        write_reg(sdspi_pkg::REG_ATTEMPTS, 20'd1);
        push_init(1'b0, 1'b0, 1);                           // v1 card slots; init arrives while CMD0 still polls
        write_reg(sdspi_pkg::REG_GAP, 20'd3);
        write_reg(sdspi_pkg::REG_ATTEMPTS, 20'd4095);
        push_init(1'b1, 1'b1, 1);                           // v2 with block addressing
        write_reg(sdspi_pkg::REG_TOKEN_POLL, 20'd0);        // zero acts as one
        slot_queue.push_back(mk_slot(sdspi_pkg::REQ_READ, 8'hFF));
        push_slots(6, 4); slot_queue.push_back(mk_slot(sdspi_pkg::REQ_CONT, 8'h00));
        push_slots(6, 4);                                   // token timeout
        write_reg(sdspi_pkg::REG_TOKEN_POLL, 20'd100);
        write_reg(sdspi_pkg::REG_BUSY_POLL, 20'd2);
        push_xfer(1'($urandom_range(0, 1)), 1'b1);          // one full block
        push_xfer(1'b1, 1'b0);                              // write rejected
        push_xfer(1'b0, 1'b0);                              // read rejected
        write_reg(sdspi_pkg::REG_RESP_POLL, 20'd255);
        write_reg(sdspi_pkg::REG_BUSY_POLL, 20'hFFFFF);
        write_reg(sdspi_pkg::REG_RESP_POLL, 20'd0);
        push_init(1'b1, 1'b0, 0);                           // v2, byte addressing
        write_reg(sdspi_pkg::REG_RESP_POLL, 20'd1);
        write_reg(sdspi_pkg::REG_TOKEN_POLL, 20'hFFFF);

        while (slot_queue.size() != 0 || i_valid || expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_slots.size() == 0)
            $display("sd_spi_host_sequencer_unit: match");
        else
            $display("sd_spi_host_sequencer_unit: mismatch");
        $finish;
    end

    initial begin
        #20000000;
        $display("sd_spi_host_sequencer_unit: mismatch");
        $finish;
    end

endmodule

### sd_spi_host_sequencer_unit.f
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_frame.sv
hw/rtl/sd_spi_host_sequencer_unit.sv
tb/tb_sd_spi_host_sequencer_unit.sv
